### sv/longest_prefix_route_lookup_defines.svh
// Assertion macros for the route lookup block.
// Plain text macros only; no dependencies.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH
`ifndef SYNTHESIS
`define LPRL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`define LPRL_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define LPRL_ASSERT(label, clk, rst_n, prop, msg)
`define LPRL_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### sv/lprl_pkg.sv
// Shared types and codes for the route lookup block.
// No dependencies.
package lprl_pkg;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// scan engine status towards the top level
	typedef struct packed {
		logic busy;
		logic done;
	} scan_sts_t;

endpackage

### sv/lprl_if.sv
// Request and response channel interfaces for the route lookup block.
// Valid/ready handshake; no dependencies.
interface lprl_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [9:0]  entry_index;
	logic [31:0] entry_prefix;
	logic [31:0] entry_mask;
	logic [31:0] entry_gateway;
	logic [3:0]  entry_port;
	logic [31:0] lookup_addr;

	modport source (output valid, op, entry_index, entry_prefix, entry_mask,
		entry_gateway, entry_port, lookup_addr, input ready);
	modport sink (input valid, op, entry_index, entry_prefix, entry_mask,
		entry_gateway, entry_port, lookup_addr, output ready);
endinterface

interface lprl_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] gateway;
	logic [3:0]  out_port;
	logic [9:0]  match_index;

	modport source (output valid, found, gateway, out_port, match_index, input ready);
	modport sink (input valid, found, gateway, out_port, match_index, output ready);
endinterface

### sv/lprl_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lprl_ram #(
	parameter int WIDTH = 100,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### sv/lprl_scan.sv
// Scan engine: walks the route RAM one entry per cycle and keeps the best match.
// Depends on lprl_pkg.
module lprl_scan import lprl_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int PB    = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                lookup_addr,
	input  logic [$clog2(DEPTH+1)-1:0] limit,
	input  logic                       take,
	output logic                       rd_en,
	output logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic [96+PB-1:0]           rd_data,
	output scan_sts_t                  sts,
	output logic                       found,
	output logic [31:0]                gateway,
	output logic [PB-1:0]              best_port,
	output logic [$clog2(DEPTH)-1:0]   best_idx
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam int W  = 96 + PB;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] limit_q;
	logic [31:0]   dest_q;
	logic          vld_s1;
	logic          last_s1;
	logic [AW-1:0] idx_s1;
	logic          hit_q;
	logic [31:0]   best_mask_q;
	logic [31:0]   best_nh_q;
	logic [PB-1:0] best_port_q;
	logic [AW-1:0] best_idx_q;

	logic [31:0]   e_prefix;
	logic [31:0]   e_mask;
	logic [31:0]   e_nh;
	logic [PB-1:0] e_port;
	logic          is_better;

	assign e_prefix = rd_data[W-1 -: 32];
	assign e_mask   = rd_data[W-33 -: 32];
	assign e_nh     = rd_data[W-65 -: 32];
	assign e_port   = rd_data[PB-1:0];

	// strict compare keeps the earliest entry on equal masks
	assign is_better = ((dest_q & e_mask) == e_prefix) && (!hit_q || (e_mask > best_mask_q));

	assign rd_en   = (state_q == S_RUN) && (cnt_q < limit_q);
	assign rd_addr = cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			vld_s1  <= rd_en;
			last_s1 <= rd_en && ((cnt_q + CW'(1)) == limit_q);
			if (rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= (limit == '0) ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					if (vld_s1 && is_better) begin
						hit_q <= 1'b1;
					end
					if (vld_s1 && last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		if (start && (state_q == S_IDLE)) begin
			dest_q  <= lookup_addr;
			limit_q <= limit;
		end
		if ((state_q == S_RUN) && vld_s1 && is_better) begin
			best_mask_q <= e_mask;
			best_nh_q   <= e_nh;
			best_port_q <= e_port;
			best_idx_q  <= idx_s1;
		end
	end

	assign sts.busy  = (state_q != S_IDLE);
	assign sts.done  = (state_q == S_DONE);
	assign found     = hit_q;
	assign gateway   = hit_q ? best_nh_q : '0;
	assign best_port = hit_q ? best_port_q : '0;
	assign best_idx  = hit_q ? best_idx_q : '0;
endmodule

### sv/longest_prefix_route_lookup.sv
// Channel | dir | beat carries
// --------+-----+------------------------------------------------------------
// req     | in  | op, entry_index, entry_prefix, entry_mask, entry_gateway,
//         |     | entry_port, lookup_addr (write a route or look up an address)
// rsp     | out | found, gateway, out_port, match_index (one per lookup)
// cfg     | in  | cfg_we / cfg_wdata: entries_in_use, 11 bits
//
// A write beat goes straight into the route RAM. A lookup reads
// N = min(entries_in_use, TABLE_DEPTH) entries, one RAM read a cycle; each
// registered read is compared, and the result is then loaded into the output
// register. req.ready is low from a lookup's acceptance until its result leaves
// the scan engine; with rsp stalled and the output register full, the next
// finished lookup waits in the engine. Reset clears control only; no clearing pass.
// Depends on lprl_pkg, lprl_if, lprl_ram, lprl_scan and the defines.
`include "longest_prefix_route_lookup_defines.svh"

module longest_prefix_route_lookup import lprl_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int PORT_BITS   = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [10:0]  cfg_wdata,
	lprl_req_if.sink     req,
	lprl_rsp_if.source   rsp
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > 11) ? CW : 11;   // wide enough for both sides of a compare
	localparam int RW = 96 + PORT_BITS;        // prefix, mask, next hop, port

	logic [10:0]    eiu_q;
	logic [CW-1:0]  limit_w;
	logic           accept;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [RW-1:0]  ram_wdata;
	logic           scan_start;
	logic           scan_rd_en;
	logic [AW-1:0]  scan_rd_addr;
	logic [RW-1:0]  ram_rdata;
	scan_sts_t      sts;
	logic           scan_found;
	logic [31:0]    scan_nh;
	logic [PORT_BITS-1:0] scan_port;
	logic [AW-1:0]  scan_idx;
	logic           load;
	logic           miss_dirty;

	logic           rsp_valid_q;
	logic           found_q;
	logic [31:0]    gateway_q;
	logic [3:0]     out_port_q;
	logic [9:0]     match_index_q;

	// entries_in_use register; counts above the table saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q <= '0;
		end else if (cfg_we) begin
			eiu_q <= cfg_wdata;
		end
	end

	assign limit_w = (LW'(eiu_q) > LW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(eiu_q);

	// request side: one item at a time, writes go straight to the RAM
	assign req.ready  = !sts.busy;
	assign accept     = req.valid && req.ready;
	assign ram_we     = accept && (req.op == OP_WRITE) &&
		(LW'(req.entry_index) < LW'(TABLE_DEPTH));
	assign ram_waddr  = AW'(req.entry_index);
	assign ram_wdata  = {req.entry_prefix, req.entry_mask, req.entry_gateway,
		PORT_BITS'(req.entry_port)};
	assign scan_start = accept && (req.op == OP_LOOKUP);

	lprl_ram #(
		.WIDTH (RW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (scan_rd_en),
		.raddr (scan_rd_addr),
		.rdata (ram_rdata)
	);

	lprl_scan #(
		.DEPTH (TABLE_DEPTH),
		.PB    (PORT_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (scan_start),
		.lookup_addr (req.lookup_addr),
		.limit       (limit_w),
		.take        (load),
		.rd_en       (scan_rd_en),
		.rd_addr     (scan_rd_addr),
		.rd_data     (ram_rdata),
		.sts         (sts),
		.found       (scan_found),
		.gateway     (scan_nh),
		.best_port   (scan_port),
		.best_idx    (scan_idx)
	);

	// output register: takes a finished result whenever it is empty or draining
	assign load = sts.done && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found_q       <= scan_found;
			gateway_q     <= scan_nh;
			out_port_q    <= 4'(scan_port);
			match_index_q <= 10'(scan_idx);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.gateway     = gateway_q;
	assign rsp.out_port    = out_port_q;
	assign rsp.match_index = match_index_q;

	// a miss beat must carry all-zero fields
	assign miss_dirty = rsp.valid && !rsp.found &&
		(|{rsp.gateway, rsp.out_port, rsp.match_index});

	// checks
	`LPRL_ASSERT(a_load_shows, clk, arst_n, load |=> rsp_valid_q, "finished result not presented")
	`LPRL_NEVER(a_miss_zero, clk, arst_n, miss_dirty, "miss result not zero")
	`LPRL_ASSERT(a_rd_bound, clk, arst_n, scan_rd_en |-> (CW'(scan_rd_addr) < limit_w), "read past count")
	`LPRL_NEVER(a_wr_in_scan, clk, arst_n, ram_we && sts.busy, "route write during a scan")
endmodule

### sim/lprl_route_checker.sv
// Checker for the route lookup block: watches req, rsp and the config port,
// keeps its own route table and predicts each lookup result.
// Depends on lprl_pkg and lprl_if.
`timescale 1ns / 1ps

module lprl_route_checker import lprl_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int PORT_BITS   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	lprl_req_if         req,
	lprl_rsp_if         rsp,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		bit [31:0] prefix;
		bit [31:0] mask;
		bit [31:0] gw;
		bit [3:0]  port;
	} route_t;

	typedef struct packed {
		bit        found;
		bit [31:0] gateway;
		bit [3:0]  out_port;
		bit [9:0]  match_index;
	} lookup_res_t;

	route_t      routes [TABLE_DEPTH];
	bit [10:0]   route_count;
	lookup_res_t pending_lookups [$];
	lookup_res_t want, got;
	int          errors;

	// linear scan, longest mask wins, earliest entry on a tie
	function automatic lookup_res_t predict_lookup(bit [31:0] dest);
		lookup_res_t res;
		int          limit;
		int          best;
		res   = '0;
		best  = 0;
		limit = (route_count > TABLE_DEPTH) ? TABLE_DEPTH : route_count;
		for (int i = 0; i < limit; i++) begin
			if ((dest & routes[i].mask) == routes[i].prefix) begin
				if (!res.found || routes[i].mask > routes[best].mask) begin
					res.found = 1'b1;
					best      = i;
				end
			end
		end
		if (res.found) begin
			res.gateway     = routes[best].gw;
			res.out_port    = routes[best].port;
			res.match_index = best[9:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count = '0;
			pending_lookups.delete();
			pending    <= 0;
		end else begin
			// results first: a result never belongs to a lookup taken on the same edge
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.found, rsp.gateway, rsp.out_port, rsp.match_index};
				if (pending_lookups.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result found=%0b gw=%h port=%0d index=%0d",
							$realtime, got.found, got.gateway, got.out_port,
							got.match_index);
				end else begin
					want = pending_lookups.pop_front();
					if (got.found != want.found || got.gateway != want.gateway ||
							got.out_port != want.out_port ||
							got.match_index != want.match_index) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: lookup mismatch exp found=%0b gw=%h port=%0d",
								" index=%0d, got found=%0b gw=%h port=%0d index=%0d"},
								$realtime, want.found, want.gateway, want.out_port,
								want.match_index, got.found, got.gateway, got.out_port,
								got.match_index);
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.op == OP_WRITE) begin
					if (req.entry_index < TABLE_DEPTH)
						routes[req.entry_index] = '{req.entry_prefix, req.entry_mask,
							req.entry_gateway, req.entry_port & 4'((1 << PORT_BITS) - 1)};
				end else begin
					pending_lookups.push_back(predict_lookup(req.lookup_addr));
				end
			end
			if (cfg_we)
				route_count = cfg_wdata;
			pending <= pending_lookups.size();
		end
	end

	assign fail_count = errors;

endmodule

### sim/longest_prefix_route_lookup_tb.sv
// Testbench top for the route lookup block: drives route writes, lookups and
// the entry count, stalls both channels at random and gives the verdict.
// Depends on lprl_pkg, lprl_if, the block and lprl_route_checker.
`timescale 1ns / 1ps

module longest_prefix_route_lookup_tb;
	import lprl_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int PORT_BITS   = 4;
	// watchdog bound, well above the slowest correct run
	localparam int CYCLE_LIMIT = 1000000;
	// long receiver hold-off, enough for the block to fill and stall req
	localparam int HOLD_CYCLES = 1500;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	int          fail_count;
	int          pending;

	lprl_req_if req_ch ();
	lprl_rsp_if rsp_ch ();

	// which table positions hold a route; a lookup must never reach an unwritten one
	bit          written [TABLE_DEPTH];
	// addresses that most routes and destinations of a phase are built around
	bit [31:0]   bases [8];
	// no sender gaps while set
	bit          burst;
	// set by stimulus, taken and cleared by the receiver process
	bit          hold_off_req;

	longest_prefix_route_lookup #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PORT_BITS   (PORT_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	lprl_route_checker #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PORT_BITS   (PORT_BITS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one beat on req and return in the time step of its acceptance.
	// valid stays high into the next beat when there is no gap, so it is never
	// dropped and raised within one step.
	task automatic send_beat(input logic op, input logic [9:0] idx,
			input logic [31:0] pfx, input logic [31:0] msk, input logic [31:0] nh,
			input logic [3:0] port, input logic [31:0] dest);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 50)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 40);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.op            <= op;
		req_ch.entry_index   <= idx;
		req_ch.entry_prefix  <= pfx;
		req_ch.entry_mask    <= msk;
		req_ch.entry_gateway <= nh;
		req_ch.entry_port    <= port;
		req_ch.lookup_addr   <= dest;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// lookup_addr is don't-care on a write, so it carries noise
	task automatic write_route(input logic [9:0] idx, input logic [31:0] pfx,
			input logic [31:0] msk, input logic [31:0] nh, input logic [3:0] port);
		send_beat(OP_WRITE, idx, pfx, msk, nh, port, $urandom);
		written[idx] = 1'b1;
	endtask

	// entry fields are don't-care on a lookup, so they carry noise
	task automatic lookup(input logic [31:0] dest);
		send_beat(OP_LOOKUP, 10'($urandom_range(0, 1023)), $urandom, $urandom,
			$urandom, 4'($urandom_range(0, 15)), dest);
	endtask

	// Mostly well-formed routes around the phase's bases; some with a mask that
	// is not contiguous, some with prefix bits outside the mask (never match).
	task automatic store_random_route(input int idx);
		int        r;
		int        len;
		bit [31:0] msk;
		bit [31:0] pfx;
		bit [31:0] nh;
		r   = $urandom_range(0, 99);
		len = ($urandom_range(0, 3) == 0) ? 8 * $urandom_range(0, 4) : $urandom_range(0, 32);
		msk = (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
		if (r < 75) begin
			pfx = bases[$urandom_range(0, 7)] & msk;
		end else if (r < 88) begin
			msk = $urandom;
			pfx = bases[$urandom_range(0, 7)] & msk;
		end else begin
			pfx = $urandom;
		end
		r  = $urandom_range(0, 99);
		nh = (r < 10) ? 32'h0 : (r < 15) ? 32'hFFFF_FFFF : 32'($urandom);
		write_route(10'(idx), pfx, msk, nh, 4'($urandom_range(0, 15)));
	endtask

	function automatic bit [31:0] random_dest();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return bases[$urandom_range(0, 7)] ^ (32'($urandom) >> $urandom_range(0, 32));
		else if (r < 85)
			return 32'h0;
		else if (r < 90)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// Register write only once the block is idle: every lookup answered, and any
	// trailing route write given time to land.
	task automatic set_route_count(input logic [10:0] n);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Fill any unwritten entry below n, make n entries live, then a mix of
	// lookups and route rewrites. hold asks the receiver for a long hold-off.
	task automatic random_phase(input int n, input int items, input bit hold);
		int r;
		for (int k = 0; k < 8; k++) begin
			r        = $urandom_range(0, 99);
			bases[k] = (r < 10) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF : 32'($urandom);
		end
		for (int i = 0; i < n; i++)
			if (!written[i])
				store_random_route(i);
		set_route_count(11'(n));
		burst = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < items; k++) begin
			if (hold && k == 2)
				hold_off_req = 1'b1;
			if ($urandom_range(0, 3) == 0)
				store_random_route($urandom_range(0, (n + 15 > 1023) ? 1023 : n + 15));
			else
				lookup(random_dest());
		end
		burst = 1'b0;
	endtask

	// Receiver: short stalls, long ready runs, the odd long stall, and the
	// requested hold-off counted here.
	initial begin
		int r;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					rsp_ch.ready <= 1'b1;
					repeat ($urandom_range(1, 30)) @(posedge clk);
				end else if (r < 80) begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else if (r < 95) begin
					rsp_ch.ready <= 1'b1;
					repeat ($urandom_range(50, 200)) @(posedge clk);
				end else begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(10, 60)) @(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("longest_prefix_route_lookup_tb: FAIL");
		$finish;
	end

	initial begin
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		req_ch.valid         <= 1'b0;
		req_ch.op            <= OP_WRITE;
		req_ch.entry_index   <= '0;
		req_ch.entry_prefix  <= '0;
		req_ch.entry_mask    <= '0;
		req_ch.entry_gateway <= '0;
		req_ch.entry_port    <= '0;
		req_ch.lookup_addr   <= '0;
		burst                 = 1'b0;
		hold_off_req          = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// count is zero out of reset: nothing is searched, no match
		lookup(32'h0000_0000);
		lookup(32'hFFFF_FFFF);
		write_route(10'd0,    32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'd1);
		write_route(10'd1,    32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 4'd2);
		// same prefix and mask as entry 1: the earlier entry must win
		write_route(10'd2,    32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_01FE, 4'd3);
		write_route(10'd3,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
		// default route, directly connected
		write_route(10'd4,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd0);
		// longer prefix behind shorter ones
		write_route(10'd5,    32'h0A01_0200, 32'hFFFF_FF00, 32'h0000_0000, 4'd5);
		// top of the table: a write at the last position, never searched
		write_route(10'd1023, 32'hC0A8_0101, 32'hFFFF_FFFF, 32'h1234_5678, 4'd9);
		set_route_count(11'd4);
		lookup(32'hC0A8_0001);
		lookup(32'h0A01_0505);
		lookup(32'hFFFF_FFFF);
		lookup(32'h0A7F_0000);
		set_route_count(11'd6);
		lookup(32'h0A01_0203);
		lookup(32'h0102_0304);
		lookup(32'h0A02_0000);
		lookup(32'h0000_0000);

		// --- random, small tables ---
		random_phase(1, 40, 1'b0);
		random_phase(8, 50, 1'b0);
		random_phase(8, 50, 1'b1);
		random_phase(30, 50, 1'b0);

		// --- larger table: longer scans ---
		random_phase(128, 40, 1'b0);
		// count back to zero: nothing searched
		set_route_count(11'd0);
		repeat (2) lookup(random_dest());
		lookup(32'h0000_0000);

		// --- random, small tables again ---
		random_phase(3, 40, 1'b0);
		random_phase(64, 50, 1'b0);
		random_phase(16, 70, 1'b0);
		random_phase(2, 50, 1'b0);

		// drain, then give stray beats a chance to show
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("longest_prefix_route_lookup_tb: PASS");
		else
			$display("longest_prefix_route_lookup_tb: FAIL");
		$finish;
	end

endmodule
